[hw/rtl/cmx_pkg.sv]
// package for the 3x3 covariance block: widths, payload types, lane and pair tables
// no dependencies; every other file of the block depends on it
`default_nettype none

package cmx_pkg;

	localparam int SMP_W     = 16;
	localparam int CSUM_W    = 21;
	localparam int PSUM_W    = 37;
	localparam int PROD_W    = 42;
	localparam int COV_W     = 40;
	localparam int FRAC_W    = 8;
	localparam int CNT_W     = 4;
	localparam int IDX_W     = 2;
	localparam int SLOT_W    = 3;
	localparam int NUM_LANES = 6;
	localparam int NUM_COMP  = 3;

	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic signed [CSUM_W-1:0] csum_t;
	typedef logic signed [PSUM_W-1:0] psum_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COV_W-1:0]  cov_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [SLOT_W-1:0]        slot_t;

	localparam idx_t COMP_X = 2'd0;
	localparam idx_t COMP_Y = 2'd1;
	localparam idx_t COMP_Z = 2'd2;

	localparam slot_t SLOT_XX = 3'd0;
	localparam slot_t SLOT_XY = 3'd1;
	localparam slot_t SLOT_XZ = 3'd2;
	localparam slot_t SLOT_YY = 3'd3;
	localparam slot_t SLOT_YZ = 3'd4;
	localparam slot_t SLOT_ZZ = 3'd5;

	// operand components of each product lane, in slot order
	localparam idx_t LANE_A [NUM_LANES] = '{COMP_X, COMP_X, COMP_X, COMP_Y, COMP_Y, COMP_Z};
	localparam idx_t LANE_B [NUM_LANES] = '{COMP_X, COMP_Y, COMP_Z, COMP_Y, COMP_Z, COMP_Z};

	typedef struct packed {
		logic  vld;
		prod_t num;
	} num_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [COV_W-1:0] quot;
	} div_stat_t;

	function automatic slot_t pair_slot(input idx_t r, input idx_t c);
		slot_t s;
		unique case ({r, c}) inside
			{COMP_X, COMP_X}:                   s = SLOT_XX;
			{COMP_X, COMP_Y}, {COMP_Y, COMP_X}: s = SLOT_XY;
			{COMP_X, COMP_Z}, {COMP_Z, COMP_X}: s = SLOT_XZ;
			{COMP_Y, COMP_Y}:                   s = SLOT_YY;
			{COMP_Y, COMP_Z}, {COMP_Z, COMP_Y}: s = SLOT_YZ;
			{COMP_Z, COMP_Z}:                   s = SLOT_ZZ;
			default:                            s = SLOT_XX;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/cmx_if.sv]
// handshake channels of the covariance block: sample intake and matrix entry output
// depends on cmx_pkg for the payload types
`default_nettype none

interface cmx_sample_if;
	logic          valid;
	logic          ready;
	cmx_pkg::smp_t sample_x;
	cmx_pkg::smp_t sample_y;
	cmx_pkg::smp_t sample_z;

	modport source(output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink(input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface cmx_entry_if;
	logic          valid;
	logic          ready;
	cmx_pkg::idx_t row_index;
	cmx_pkg::idx_t col_index;
	cmx_pkg::cov_t cov_value;
	logic          last_entry;

	modport source(output valid, output row_index, output col_index, output cov_value,
		output last_entry, input ready);
	modport sink(input valid, input row_index, input col_index, input cov_value,
		input last_entry, output ready);
endinterface

`default_nettype wire

[hw/rtl/cmx_lane.sv]
// one product lane: registered 16x16 multiply feeding a 37-bit running sum
// depends on cmx_pkg
`default_nettype none

module cmx_lane (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  cmx_pkg::smp_t op_a,
	input  cmx_pkg::smp_t op_b,
	input  logic          clr,
	output cmx_pkg::psum_t sum
);
	import cmx_pkg::*;

	logic signed [2*SMP_W-1:0] prod_s1;
	logic                      vld_s1;
	psum_t                     acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
			vld_s1  <= 1'b0;
			acc_q   <= '0;
		end else begin
			prod_s1 <= op_a * op_b;
			vld_s1  <= vld;
			if (clr) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= acc_q + PSUM_W'(prod_s1);
			end
		end
	end

	assign sum = acc_q;

endmodule

`default_nettype wire

[hw/rtl/cmx_merge.sv]
// merging stage: picks the sums of one matrix entry and forms N*Sab - Sa*Sb
// two registered stages; depends on cmx_pkg
`default_nettype none

module cmx_merge #(
	parameter int NUM_POINTS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cmx_pkg::idx_t  row,
	input  cmx_pkg::idx_t  col,
	input  cmx_pkg::psum_t psum [cmx_pkg::NUM_LANES],
	input  cmx_pkg::csum_t csum [cmx_pkg::NUM_COMP],
	output cmx_pkg::num_t  num
);
	import cmx_pkg::*;

	localparam logic signed [CNT_W:0] N_S = (CNT_W+1)'(NUM_POINTS);

	psum_t psum_sel;
	prod_t nprod_s1;
	prod_t cprod_s1;
	logic  vld_s1;
	prod_t num_s2;
	logic  vld_s2;

	assign psum_sel = psum[pair_slot(row, col)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nprod_s1 <= '0;
			cprod_s1 <= '0;
			vld_s1   <= 1'b0;
			num_s2   <= '0;
			vld_s2   <= 1'b0;
		end else begin
			nprod_s1 <= psum_sel * N_S;
			cprod_s1 <= csum[row] * csum[col];
			vld_s1   <= start;
			num_s2   <= nprod_s1 - cprod_s1;
			vld_s2   <= vld_s1;
		end
	end

	assign num.vld = vld_s2;
	assign num.num = num_s2;

endmodule

`default_nettype wire

[hw/rtl/cmx_div.sv]
// |num| * 2^8 / N^2 as a multiply by a constant reciprocal, three registered stages
// depends on cmx_pkg
`default_nettype none

module cmx_div #(
	parameter int DIVISOR = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmx_pkg::num_t      num,
	output cmx_pkg::div_stat_t stat
);
	import cmx_pkg::*;

	localparam int MAG_W = PROD_W;
	localparam int LO_W  = 26;
	localparam int HI_W  = MAG_W - LO_W;
	localparam int REC_W = 2 * LO_W;
	localparam int DIV_L = $clog2(DIVISOR);
	localparam int SHIFT = MAG_W + FRAC_W + DIV_L;
	localparam int RSH   = MAG_W + DIV_L - LO_W;
	localparam int PHI_W = HI_W + LO_W;
	localparam int PLO_W = 2 * LO_W;
	localparam int MID_W = PLO_W + 1;
	localparam int TOT_W = PHI_W + LO_W + 1;
	localparam logic [63:0] REC_64 =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [LO_W-1:0] REC_LO = REC_64[LO_W-1:0];
	localparam logic [LO_W-1:0] REC_HI = REC_64[REC_W-1:LO_W];

	logic [MAG_W-1:0] mag;
	logic [HI_W-1:0]  a_hi;
	logic [LO_W-1:0]  a_lo;
	logic [PHI_W-1:0] p_hh_s1;
	logic [PHI_W-1:0] p_hl_s1;
	logic [PLO_W-1:0] p_lh_s1;
	logic [PLO_W-1:0] p_ll_s1;
	logic             vld_s1;
	logic             neg_s1;
	logic [PHI_W-1:0] p_hh_s2;
	logic [MID_W-1:0] mid_s2;
	logic             vld_s2;
	logic             neg_s2;
	logic [MID_W-1:0] mid_sum;
	logic [TOT_W-1:0] tot_sum;
	logic [COV_W-1:0] quot_q;
	logic             neg_q;
	logic             done_q;

	assign mag  = num.num[PROD_W-1] ? -num.num : num.num;
	assign a_hi = mag[MAG_W-1:LO_W];
	assign a_lo = mag[LO_W-1:0];

	// middle partial products plus the upper half of the lowest one
	assign mid_sum = MID_W'(p_lh_s1) + MID_W'(p_hl_s1) + MID_W'(p_ll_s1[PLO_W-1:LO_W]);
	assign tot_sum = TOT_W'({p_hh_s2, {LO_W{1'b0}}}) + TOT_W'(mid_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_hh_s1 <= '0;
			p_hl_s1 <= '0;
			p_lh_s1 <= '0;
			p_ll_s1 <= '0;
			vld_s1  <= 1'b0;
			neg_s1  <= 1'b0;
			p_hh_s2 <= '0;
			mid_s2  <= '0;
			vld_s2  <= 1'b0;
			neg_s2  <= 1'b0;
			quot_q  <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1 <= num.vld;
			if (num.vld) begin
				p_hh_s1 <= a_hi * REC_HI;
				p_hl_s1 <= a_hi * REC_LO;
				p_lh_s1 <= a_lo * REC_HI;
				p_ll_s1 <= a_lo * REC_LO;
				neg_s1  <= num.num[PROD_W-1];
			end
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				p_hh_s2 <= p_hh_s1;
				mid_s2  <= mid_sum;
				neg_s2  <= neg_s1;
			end
			done_q <= vld_s2;
			if (vld_s2) begin
				quot_q <= tot_sum[RSH +: COV_W];
				neg_q  <= neg_s2;
			end
		end
	end

	assign stat.done = done_q;
	assign stat.neg  = neg_q;
	assign stat.quot = quot_q;

endmodule

`default_nettype wire

[hw/rtl/covariance_matrix_3d.sv]
// top level of the 3x3 population covariance block
// depends on cmx_pkg, cmx_if, cmx_lane, cmx_merge, cmx_div
//
// channel   | dir | payload                                          | accepted at
// samples   | in  | sample_x, sample_y, sample_z (16b signed each)   | valid & ready
// entries   | out | row_index, col_index, cov_value (40b Q8), last   | valid & ready
//
// samples: one item per cycle while a set is being collected
// after the last sample and a drain state, nine entries follow one after another:
// two numerator stages, three reciprocal multiply stages, a wait for done, the output load
// entries do not overlap; samples wait until the ninth entry is loaded
// reset clears all sums and counters at once; there is no clearing pass
// a stalled output holds its entry and the sequencer waits with the next one
`default_nettype none

module covariance_matrix_3d #(
	parameter int NUM_POINTS = 10
) (
	input  logic clk,
	input  logic arst_n,
	cmx_sample_if.sink  samples,
	cmx_entry_if.source entries
);
	import cmx_pkg::*;

	localparam int DIVISOR = NUM_POINTS * NUM_POINTS;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_POINTS - 1);

	typedef enum logic [2:0] {S_ACC, S_DRAIN, S_START, S_CALC, S_PUT} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	idx_t             row_q;
	idx_t             col_q;
	csum_t            csum_q [NUM_COMP];
	logic             out_vld_q;
	idx_t             out_row_q;
	idx_t             out_col_q;
	cov_t             out_cov_q;
	logic             out_last_q;

	smp_t      comp [NUM_COMP];
	psum_t     psum [NUM_LANES];
	num_t      num;
	div_stat_t stat;
	logic      in_acc;
	logic      put_ok;
	logic      put_e;
	logic      last_e;
	logic      clr;
	cov_t      quot_s;

	assign comp[0] = samples.sample_x;
	assign comp[1] = samples.sample_y;
	assign comp[2] = samples.sample_z;

	assign samples.ready = (state_q == S_ACC);
	assign in_acc        = samples.valid && samples.ready;
	assign put_ok        = !out_vld_q || entries.ready;
	assign put_e         = (state_q == S_PUT) && put_ok;
	assign last_e        = (row_q == COMP_Z) && (col_q == COMP_Z);
	assign clr           = put_e && last_e;
	assign quot_s        = $signed(stat.quot);

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		cmx_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (in_acc),
			.op_a   (comp[LANE_A[l]]),
			.op_b   (comp[LANE_B[l]]),
			.clr    (clr),
			.sum    (psum[l])
		);
	end

	cmx_merge #(
		.NUM_POINTS (NUM_POINTS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_START),
		.row    (row_q),
		.col    (col_q),
		.psum   (psum),
		.csum   (csum_q),
		.num    (num)
	);

	cmx_div #(
		.DIVISOR (DIVISOR)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_ACC;
			cnt_q      <= '0;
			row_q      <= COMP_X;
			col_q      <= COMP_X;
			for (int i = 0; i < NUM_COMP; i++) begin
				csum_q[i] <= '0;
			end
			out_vld_q  <= 1'b0;
			out_row_q  <= COMP_X;
			out_col_q  <= COMP_X;
			out_cov_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (put_e) begin
				out_vld_q <= 1'b1;
			end else if (entries.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_ACC: begin
					if (in_acc) begin
						for (int i = 0; i < NUM_COMP; i++) begin
							csum_q[i] <= csum_q[i] + CSUM_W'(comp[i]);
						end
						if (cnt_q == LAST_CNT) begin
							cnt_q   <= '0;
							state_q <= S_DRAIN;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (stat.done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (put_ok) begin
						out_row_q  <= row_q;
						out_col_q  <= col_q;
						out_cov_q  <= stat.neg ? -quot_s : quot_s;
						out_last_q <= last_e;
						if (last_e) begin
							row_q   <= COMP_X;
							col_q   <= COMP_X;
							for (int i = 0; i < NUM_COMP; i++) begin
								csum_q[i] <= '0;
							end
							state_q <= S_ACC;
						end else begin
							if (col_q == COMP_Z) begin
								col_q <= COMP_X;
								row_q <= row_q + IDX_W'(1);
							end else begin
								col_q <= col_q + IDX_W'(1);
							end
							state_q <= S_START;
						end
					end
				end
				default: begin
					state_q <= S_ACC;
				end
			endcase
		end
	end

	assign entries.valid      = out_vld_q;
	assign entries.row_index  = out_row_q;
	assign entries.col_index  = out_col_q;
	assign entries.cov_value  = out_cov_q;
	assign entries.last_entry = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/cmx_checker.sv]
// port-level checks of the covariance block, attached to the top level by bind
// depends on cmx_pkg and covariance_matrix_3d
`default_nettype none

module cmx_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input cmx_pkg::idx_t out_row,
	input cmx_pkg::idx_t out_col,
	input cmx_pkg::cov_t out_cov,
	input logic          out_last
);
	import cmx_pkg::*;

	// stalled entry holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cov) && $stable(out_row)
			&& $stable(out_col) && $stable(out_last))
		else $error("stalled entry changed");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row == COMP_X || out_row == COMP_Y || out_row == COMP_Z)
			&& (out_col == COMP_X || out_col == COMP_Y || out_col == COMP_Z))
		else $error("entry index out of range");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == (out_row == COMP_Z && out_col == COMP_Z))
		else $error("last flag not on the final entry");

	// no sample intake while a non-final entry of a matrix is on the output
	a_no_intake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("sample intake open during emission");

	// an offered sample stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("sample item withdrawn before it was taken");

endmodule

bind covariance_matrix_3d cmx_checker u_cmx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (entries.valid),
	.out_ready (entries.ready),
	.out_row   (entries.row_index),
	.out_col   (entries.col_index),
	.out_cov   (entries.cov_value),
	.out_last  (entries.last_entry)
);

`default_nettype wire

[tb/tb_covariance_matrix_3d.sv]
// self-checking testbench for covariance_matrix_3d: sample sets in, 3x3 covariance entries out
// holds its own predictor of the sums and Q8 entries, with bursty sender and stalling receiver
// depends on cmx_pkg, cmx_if and the rtl of covariance_matrix_3d
`default_nettype none

module tb_covariance_matrix_3d;
	import cmx_pkg::*;

	localparam int NPTS         = 10;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_AT      = 125;
	localparam int HOLD_LEN     = 2000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		smp_t x;
		smp_t y;
		smp_t z;
	} smp_item_t;

	typedef struct {
		idx_t row;
		idx_t col;
		cov_t cov;
		logic last;
	} entry_t;

	typedef enum {SHAPE_WIDE, SHAPE_EDGE, SHAPE_TINY, SHAPE_LINKED} set_shape_e;
	typedef enum {RX_OPEN, RX_COIN, RX_THIRDS, RX_BURSTY} rx_pattern_e;

	localparam slot_t SLOT_OF [NUM_COMP][NUM_COMP] = '{
		'{SLOT_XX, SLOT_XY, SLOT_XZ},
		'{SLOT_XY, SLOT_YY, SLOT_YZ},
		'{SLOT_XZ, SLOT_YZ, SLOT_ZZ}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      tx_valid = 1'b0;
	smp_item_t tx_item = '0;
	logic      rx_ready = 1'b0;

	cmx_sample_if samples_ch();
	cmx_entry_if  entries_ch();

	assign samples_ch.valid    = tx_valid;
	assign samples_ch.sample_x = tx_item.x;
	assign samples_ch.sample_y = tx_item.y;
	assign samples_ch.sample_z = tx_item.z;
	assign entries_ch.ready    = rx_ready;

	covariance_matrix_3d #(.NUM_POINTS(NPTS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.entries (entries_ch)
	);

	always #5 clk = ~clk;

	smp_item_t pending_samples [$];
	entry_t    entries_due [$];

	int     set_fill;
	longint comp_sum [NUM_COMP];
	longint prod_sum [NUM_LANES];
	int     sets_done;
	int     fed_cnt;
	int     checked_cnt;
	int     fail_cnt;
	int     cycles;

	// running sums of the current set; nine entries are due once the set is full
	task automatic accumulate_sample(input smp_item_t s);
		longint v [NUM_COMP];
		longint num;
		longint quo;
		entry_t e;
		v[0] = s.x;
		v[1] = s.y;
		v[2] = s.z;
		for (int a = 0; a < NUM_COMP; a++) begin
			comp_sum[a] += v[a];
			for (int b = a; b < NUM_COMP; b++)
				prod_sum[SLOT_OF[a][b]] += v[a] * v[b];
		end
		set_fill++;
		if (set_fill == NPTS) begin
			for (int a = 0; a < NUM_COMP; a++) begin
				for (int b = 0; b < NUM_COMP; b++) begin
					num = longint'(NPTS) * prod_sum[SLOT_OF[a][b]] - comp_sum[a] * comp_sum[b];
					quo = (num * (longint'(1) << FRAC_W)) / longint'(NPTS * NPTS);
					e.row  = idx_t'(a);
					e.col  = idx_t'(b);
					e.cov  = quo[COV_W-1:0];
					e.last = (a == NUM_COMP - 1) && (b == NUM_COMP - 1);
					entries_due.push_back(e);
				end
			end
			set_fill = 0;
			foreach (comp_sum[i]) comp_sum[i] = 0;
			foreach (prod_sum[i]) prod_sum[i] = 0;
			sets_done++;
		end
	endtask

	function automatic smp_t rand_comp(input set_shape_e shape);
		smp_t c;
		case (shape)
			SHAPE_EDGE: begin
				case ($urandom_range(0, 6))
					0: c = -16'sd32768;
					1: c = -16'sd32767;
					2: c = -16'sd1;
					3: c = 16'sd0;
					4: c = 16'sd1;
					5: c = 16'sd32766;
					default: c = 16'sd32767;
				endcase
			end
			SHAPE_TINY: c = smp_t'(int'($urandom_range(0, 8)) - 4);
			default: c = smp_t'($urandom);
		endcase
		return c;
	endfunction

	// sender: bursts of items with random gaps, valid held until the item is taken
	int tx_idx;
	int burst_left;
	int gap_left;

	always @(negedge clk) begin
		if (arst_n && !(tx_valid && fed_cnt == tx_idx)) begin
			if (gap_left > 0) begin
				tx_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (fed_cnt < pending_samples.size()) begin
				tx_valid <= 1'b1;
				tx_item  <= pending_samples[fed_cnt];
				tx_idx   <= fed_cnt;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 25);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				tx_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && samples_ch.valid && samples_ch.ready) begin
			accumulate_sample('{samples_ch.sample_x, samples_ch.sample_y, samples_ch.sample_z});
			fed_cnt <= fed_cnt + 1;
		end
	end

	// receiver: rotating stall patterns, plus one long hold-off to back up the input
	int          rx_tick;
	int          stall_left;
	int          hold_left;
	logic        hold_done = 1'b0;
	rx_pattern_e rx_mode;

	assign rx_mode = rx_pattern_e'((rx_tick / 200) % 4);

	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rx_ready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && fed_cnt >= HOLD_AT) begin
			rx_ready  <= 1'b0;
			hold_left <= HOLD_LEN - 1;
			hold_done <= 1'b1;
		end else begin
			rx_tick <= rx_tick + 1;
			case (rx_mode)
				RX_OPEN:   rx_ready <= 1'b1;
				RX_COIN:   rx_ready <= $urandom_range(0, 1);
				RX_THIRDS: rx_ready <= (rx_tick % 3 != 0);
				default: begin
					if (stall_left > 0) begin
						rx_ready   <= 1'b0;
						stall_left <= stall_left - 1;
					end else begin
						rx_ready <= 1'b1;
						if ($urandom_range(0, 19) == 0)
							stall_left <= $urandom_range(1, 80);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		entry_t got;
		entry_t want;
		if (arst_n && entries_ch.valid && entries_ch.ready) begin
			got = '{entries_ch.row_index, entries_ch.col_index, entries_ch.cov_value,
				entries_ch.last_entry};
			if (entries_due.size() == 0) begin
				$error("unexpected entry: row_index %0d col_index %0d cov_value %0d",
					got.row, got.col, got.cov);
				fail_cnt++;
			end else begin
				want = entries_due.pop_front();
				checked_cnt++;
				if (got.row !== want.row) begin
					$error("row_index: expected %0d, actual %0d", want.row, got.row);
					fail_cnt++;
				end
				if (got.col !== want.col) begin
					$error("col_index: expected %0d, actual %0d", want.col, got.col);
					fail_cnt++;
				end
				if (got.cov !== want.cov) begin
					$error("cov_value: expected %0d, actual %0d", want.cov, got.cov);
					fail_cnt++;
				end
				if (got.last !== want.last) begin
					$error("last_entry: expected %0d, actual %0d", want.last, got.last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d entries still due", cycles, entries_due.size());
		$display("FAIL covariance_matrix_3d");
		$finish;
	end

	initial begin
		set_shape_e shape;
		smp_t       base;
		// full-scale swings, x and y anti-correlated, z nearly uncorrelated with both
		for (int i = 0; i < NPTS; i++)
			pending_samples.push_back('{
				(i % 2 == 0) ? 16'sd32767 : -16'sd32768,
				(i % 2 == 0) ? -16'sd32768 : 16'sd32767,
				(i % 4 < 2) ? 16'sd32767 : -16'sd32768});
		// constant set, x and y at the extremes, zero covariance
		for (int i = 0; i < NPTS; i++)
			pending_samples.push_back('{-16'sd32768, 16'sd32767, -16'sd1});
		for (int s = 0; s < 34; s++) begin
			shape = set_shape_e'($urandom_range(0, 3));
			for (int i = 0; i < NPTS; i++) begin
				if (shape == SHAPE_LINKED) begin
					base = rand_comp(SHAPE_WIDE);
					pending_samples.push_back('{base, -base,
						smp_t'(base + $urandom_range(0, 64) - 32)});
				end else begin
					pending_samples.push_back('{rand_comp(shape), rand_comp(shape),
						rand_comp(shape)});
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (fed_cnt == pending_samples.size());
		wait (entries_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d samples in %0d sets fed, %0d covariance entries checked in %0d cycles",
			fed_cnt, sets_done, checked_cnt, cycles);
		$display("output held off once for %0d cycles with the input still offering items",
			HOLD_LEN);
		if (fail_cnt == 0) begin
			$display("PASS covariance_matrix_3d");
		end else begin
			$display("FAIL covariance_matrix_3d");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/cmx_pkg.sv
hw/rtl/cmx_if.sv
hw/rtl/cmx_lane.sv
hw/rtl/cmx_merge.sv
hw/rtl/cmx_div.sv
hw/rtl/covariance_matrix_3d.sv
hw/rtl/cmx_checker.sv
tb/tb_covariance_matrix_3d.sv
